// ===== hw/rtl/swle_pkg.sv =====
// Package for the star window local extrema detector.
// Holds register indexes, reset values and fixed field widths.
// No dependencies.
`default_nettype none

package swle_pkg;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS       = 2'd2;

  // Register widths
  localparam int FRAME_WIDTH_BITS  = 11;
  localparam int FRAME_HEIGHT_BITS = 16;
  localparam int RADIUS_BITS       = 3;

  // Register reset values
  localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd1024;
  localparam logic [RADIUS_BITS-1:0]       RADIUS_RESET       = 3'd1;

  // Row coordinate width of a result
  localparam int ROW_BITS = 16;

endpackage

`default_nettype wire

// ===== hw/rtl/swle_if.sv =====
// Valid/ready stream interfaces of the star window local extrema detector.
// Pixel channel in, result channel out. Depends on swle_pkg.
`default_nettype none

interface swle_pixel_if #(
  parameter int PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface swle_result_if #(
  parameter int PIXEL_BITS = 8,
  parameter int COL_BITS   = 10
);
  logic                          valid;
  logic                          ready;
  logic [swle_pkg::ROW_BITS-1:0] row;
  logic [COL_BITS-1:0]           col;
  logic [PIXEL_BITS-1:0]         value;
  logic                          is_max;
  logic                          is_min;
  logic                          last;

  modport source (output valid, output row, output col, output value,
                  output is_max, output is_min, output last, input ready);
  modport sink   (input valid, input row, input col, input value,
                  input is_max, input is_min, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/swle_col_store.sv =====
// Column store: one word per frame column holding the older rows of it.
// Single synchronous RAM, registered read, write-to-read bypass.
// No package dependencies.
`default_nettype none

module swle_col_store #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 112
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WORD_BITS-1:0]     rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WORD_BITS-1:0]     wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write port, and read port with bypass when both hit the same column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/star_window_local_extrema.sv =====
// Star window local extrema detector, top level.
// Depends on swle_pkg, swle_if (swle_pixel_if, swle_result_if) and swle_col_store.
`default_nettype none

// Pixels arrive in raster order on the pixel channel, one per clock at full
// rate. Each pixel costs one read and one write of its column word in the
// column store (a single RAM of MAX_WIDTH words, each holding the previous
// 2*MAX_RADIUS rows of that column); a read and a write of the same column in
// one cycle are bypassed, so narrow frames run at full rate too. A window
// register of 2*MAX_RADIUS+1 columns shifts in one full column per pixel.
// A centre at least radius away from every edge is reported once the pixel
// radius rows below and radius columns to its right has been accepted; the
// result is registered through every stage, with is_max/is_min telling
// whether the centre is strictly above/below every pixel on its row, column
// and both diagonals within radius. Radius 0 reports every pixel with both
// flags set. Any write to a defined register restarts the frame at row 0,
// column 0; write only while the block is idle. The column store needs no
// clearing after reset. Throughput is one pixel per clock; the output
// register stalls the whole pipeline only while a result is refused.

module star_window_local_extrema #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  swle_pixel_if.sink                               pixels,
  swle_result_if.source                            results,
  input  wire logic                                write_en,
  input  wire logic [swle_pkg::CFG_INDEX_BITS-1:0] write_index,
  input  wire logic [swle_pkg::CFG_DATA_BITS-1:0]  write_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int N   = 2 * MAX_RADIUS + 1;
  localparam int KW  = $clog2(N);
  localparam int RB  = swle_pkg::ROW_BITS;
  localparam int HB  = swle_pkg::FRAME_HEIGHT_BITS;
  localparam int WORD_BITS = 2 * MAX_RADIUS * PIXEL_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [swle_pkg::FRAME_WIDTH_BITS-1:0]  frame_width;
  logic [swle_pkg::FRAME_HEIGHT_BITS-1:0] frame_height;
  logic [swle_pkg::RADIUS_BITS-1:0]       radius;
  logic                                   cfg_hit;

  assign cfg_hit = write_en && ((write_index == swle_pkg::REG_FRAME_WIDTH) ||
                                (write_index == swle_pkg::REG_FRAME_HEIGHT) ||
                                (write_index == swle_pkg::REG_RADIUS));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= swle_pkg::FRAME_WIDTH_RESET;
      frame_height <= swle_pkg::FRAME_HEIGHT_RESET;
      radius       <= swle_pkg::RADIUS_RESET;
    end else if (write_en) begin
      unique case (write_index)
        swle_pkg::REG_FRAME_WIDTH:
          frame_width <= write_data[swle_pkg::FRAME_WIDTH_BITS-1:0];
        swle_pkg::REG_FRAME_HEIGHT:
          frame_height <= write_data[swle_pkg::FRAME_HEIGHT_BITS-1:0];
        swle_pkg::REG_RADIUS:
          radius <= write_data[swle_pkg::RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry (clamped)
  logic [WW-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [RW-1:0] r_eff;
  logic [RW:0]   twice_r;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height == '0) ? HB'(1) : frame_height;
    r_eff = (32'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius);
    twice_r = {r_eff, 1'b0};
  end

  // ---------------------------------------------------------------------
  // Handshake: the pipeline moves whenever the output register is free or taken
  logic en;
  logic accept;
  logic out_v;

  assign en           = !out_v || results.ready;
  assign pixels.ready = en;
  assign accept       = pixels.valid && en;

  // ---------------------------------------------------------------------
  // Raster position counters
  logic [RB-1:0] row_cnt;
  logic [CW-1:0] col_cnt;
  logic          col_end;
  logic          row_end;

  assign col_end = ({1'b0, col_cnt} + WW'(1)) >= w_eff;
  assign row_end = ({1'b0, row_cnt} + 17'd1) >= {1'b0, h_eff};

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_cnt <= '0;
        row_cnt <= row_end ? '0 : row_cnt + RB'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: column word read; result decision and centre coordinates
  logic                  s1_valid;
  logic                  s1_res;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [CW-1:0]         s1_addr;
  logic [RB-1:0]         s1_row;
  logic [CW-1:0]         s1_col;
  logic                  s1_last;
  logic [WORD_BITS-1:0]  rd_word;
  logic [WORD_BITS-1:0]  wr_word;
  logic [PIXEL_BITS-1:0] colvec [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pixels.pixel;
      s1_addr <= col_cnt;
      s1_res  <= (32'(row_cnt) >= 32'(twice_r)) && (32'(col_cnt) >= 32'(twice_r));
      s1_row  <= row_cnt - RB'(r_eff);
      s1_col  <= col_cnt - CW'(r_eff);
      s1_last <= row_end && col_end;
    end
  end

  swle_col_store #(
    .DEPTH     (MAX_WIDTH),
    .WORD_BITS (WORD_BITS)
  ) u_col_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (rd_word),
    .wr_en   (en && s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_word)
  );

  // Full column, newest row first; write back all but the oldest
  always_comb begin
    colvec[0] = s1_pix;
    for (int k = 1; k < N; k++) begin
      colvec[k] = rd_word[(k-1)*PIXEL_BITS +: PIXEL_BITS];
    end
    for (int k = 0; k < N - 1; k++) begin
      wr_word[k*PIXEL_BITS +: PIXEL_BITS] = colvec[k];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: window register, index [column age][row age]
  logic [PIXEL_BITS-1:0] win [N][N];
  logic                  s2_valid;
  logic [RB-1:0]         s2_row;
  logic [CW-1:0]         s2_col;
  logic                  s2_last;

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      win[0] <= colvec;
      for (int j = 1; j < N; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_last <= s1_last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: pick the centre and the four star lines out of the window
  logic [PIXEL_BITS-1:0] row_sel  [N];
  logic [PIXEL_BITS-1:0] col_sel  [N];
  logic [PIXEL_BITS-1:0] anti_sel [N];
  logic [N-1:0]          used_sel;
  logic [KW-1:0]         r_idx;

  assign r_idx = KW'(r_eff);

  always_comb begin
    int a;
    for (int i = 0; i < N; i++) begin
      row_sel[i]  = win[i][r_idx];
      col_sel[i]  = win[r_idx][i];
      used_sel[i] = (i <= int'(twice_r)) && (i != int'(r_eff));
      a = int'(twice_r) - i;
      if (a >= 0) begin
        anti_sel[i] = win[i][KW'(a)];
      end else begin
        anti_sel[i] = '0;
      end
    end
  end

  logic                  s3_valid;
  logic [PIXEL_BITS-1:0] s3_centre;
  logic [PIXEL_BITS-1:0] s3_rowl [N];
  logic [PIXEL_BITS-1:0] s3_coll [N];
  logic [PIXEL_BITS-1:0] s3_diag [N];
  logic [PIXEL_BITS-1:0] s3_anti [N];
  logic [N-1:0]          s3_used;
  logic [RB-1:0]         s3_row;
  logic [CW-1:0]         s3_col;
  logic                  s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      s3_centre <= win[r_idx][r_idx];
      s3_rowl   <= row_sel;
      s3_coll   <= col_sel;
      s3_anti   <= anti_sel;
      s3_used   <= used_sel;
      for (int i = 0; i < N; i++) begin
        s3_diag[i] <= win[i][i];
      end
      s3_row    <= s2_row;
      s3_col    <= s2_col;
      s3_last   <= s2_last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: compare every star neighbor with the centre, output register
  logic mx_comb;
  logic mn_comb;

  always_comb begin
    mx_comb = 1'b1;
    mn_comb = 1'b1;
    for (int i = 0; i < N; i++) begin
      if (s3_used[i]) begin
        if (s3_centre <= s3_rowl[i] || s3_centre <= s3_coll[i] ||
            s3_centre <= s3_diag[i] || s3_centre <= s3_anti[i]) begin
          mx_comb = 1'b0;
        end
        if (s3_centre >= s3_rowl[i] || s3_centre >= s3_coll[i] ||
            s3_centre >= s3_diag[i] || s3_centre >= s3_anti[i]) begin
          mn_comb = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid) begin
      results.row    <= s3_row;
      results.col    <= s3_col;
      results.value  <= s3_centre;
      results.is_max <= mx_comb;
      results.is_min <= mn_comb;
      results.last   <= s3_last;
    end
  end

  assign results.valid = out_v;

  // ---------------------------------------------------------------------
  // Assertions

  // A pixel is only ever taken at a position inside the configured frame
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |-> (32'(col_cnt) < 32'(w_eff)) && (32'(row_cnt) < 32'(h_eff)))
    else $error("raster position outside frame at accept");

  // A register write restarts the frame
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (row_cnt == '0) && (col_cnt == '0))
    else $error("frame not restarted after register write");

  // A judged centre in the last stage reaches the output register
  a_result_reaches_out: assert property (@(posedge clk) disable iff (rst)
    en && s3_valid |=> out_v)
    else $error("result lost between compare stage and output");

  // A stalled pipeline keeps its column store transaction pending
  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    !en && s1_valid |=> s1_valid && $stable(s1_addr))
    else $error("stage 1 item lost during stall");

endmodule

`default_nettype wire

// ===== sim/tb_star_window_local_extrema.sv =====
`timescale 1ns / 1ps
// Testbench for star_window_local_extrema: directed and random pixel frames,
// each result checked against a line-buffer model of the star comparison.
// Depends on swle_pkg, swle_if (pixel and result interfaces) and the RTL top.

module tb_star_window_local_extrema;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_RADIUS     = 7;
  localparam int PIXEL_BITS     = 8;
  localparam int COL_BITS       = 10;
  localparam int LINE_ROWS      = 2 * MAX_RADIUS + 1;
  localparam int RANDOM_ITEMS   = 500;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTED    = 100;

  localparam int IDX_BITS = swle_pkg::CFG_INDEX_BITS;
  localparam int DAT_BITS = swle_pkg::CFG_DATA_BITS;
  localparam int FW_BITS  = swle_pkg::FRAME_WIDTH_BITS;
  localparam int FH_BITS  = swle_pkg::FRAME_HEIGHT_BITS;
  localparam int R_BITS   = swle_pkg::RADIUS_BITS;

  // Index with no register behind it
  localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;

  // Pixel value distributions
  localparam int PIX_FULL    = 0;
  localparam int PIX_NARROW  = 1;
  localparam int PIX_EXTREME = 2;

  typedef struct packed {
    logic [swle_pkg::ROW_BITS-1:0] row;
    logic [COL_BITS-1:0]           col;
    logic [PIXEL_BITS-1:0]         value;
    logic                          is_max;
    logic                          is_min;
    logic                          last;
  } extremum_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                write_en;
  logic [IDX_BITS-1:0] write_index;
  logic [DAT_BITS-1:0] write_data;

  swle_pixel_if  #(.PIXEL_BITS(PIXEL_BITS)) pix_if ();
  swle_result_if #(.PIXEL_BITS(PIXEL_BITS), .COL_BITS(COL_BITS)) res_if ();

  star_window_local_extrema #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .PIXEL_BITS(PIXEL_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pix_if),
    .results    (res_if),
    .write_en   (write_en),
    .write_index(write_index),
    .write_data (write_data)
  );

  // Clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Model state: geometry, line buffer, raster position
  logic [FW_BITS-1:0]    cfg_width;
  logic [FH_BITS-1:0]    cfg_height;
  logic [R_BITS-1:0]     cfg_radius;
  logic [PIXEL_BITS-1:0] line_buf [LINE_ROWS][MAX_WIDTH];
  int                    next_row;
  int                    next_col;
  extremum_t             expected_q [$];
  extremum_t             want;

  // Stimulus bookkeeping
  logic [PIXEL_BITS-1:0] pixel_q [$];
  int   pushed_cnt   = 0;
  int   accepted_cnt = 0;
  int   error_count  = 0;
  logic idle_en      = 1'b1;
  logic pix_taken    = 1'b0;
  int   send_gap     = 0;
  int   hold_left    = 0;
  int   stall_asked  = 0;
  int   stall_taken  = 0;
  int   quiet_cycles = 0;

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED) $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Geometry write: any defined register restarts the frame
  function automatic void apply_reg(input logic [IDX_BITS-1:0] idx,
                                    input logic [DAT_BITS-1:0] data);
    case (idx)
      swle_pkg::REG_FRAME_WIDTH:  cfg_width  = data[FW_BITS-1:0];
      swle_pkg::REG_FRAME_HEIGHT: cfg_height = data[FH_BITS-1:0];
      swle_pkg::REG_RADIUS:       cfg_radius = data[R_BITS-1:0];
      default:                    return;
    endcase
    next_row = 0;
    next_col = 0;
  endfunction

  // Store one pixel and, once its window is complete, judge the centre
  function automatic void predict_pixel(input logic [PIXEL_BITS-1:0] pix);
    int w, h, r, row, col, crow, ccol;
    logic [PIXEL_BITS-1:0] centre, nb;
    logic up, down;
    extremum_t res;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    r = int'(cfg_radius);
    row = next_row;
    col = next_col;
    line_buf[row % LINE_ROWS][col] = pix;
    if (row >= 2 * r && col >= 2 * r) begin
      crow = row - r;
      ccol = col - r;
      centre = line_buf[crow % LINE_ROWS][ccol];
      up = 1'b1;
      down = 1'b1;
      // the eight arms of the star, out to distance r
      for (int d = 1; d <= r; d++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dy != 0 || dx != 0) begin
              nb = line_buf[(crow + dy * d) % LINE_ROWS][ccol + dx * d];
              if (centre <= nb) up = 1'b0;
              if (centre >= nb) down = 1'b0;
            end
          end
        end
      end
      res.row    = crow[swle_pkg::ROW_BITS-1:0];
      res.col    = ccol[COL_BITS-1:0];
      res.value  = centre;
      res.is_max = up;
      res.is_min = down;
      res.last   = (row + 1 >= h) && (col + 1 >= w);
      expected_q.push_back(res);
    end
    if (col + 1 >= w) begin
      next_col = 0;
      next_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      next_col = col + 1;
    end
  endfunction

  // Monitor: config writes, accepted pixels and result checks at the rising edge
  always @(posedge clk) begin
    pix_taken <= pix_if.valid && pix_if.ready;
    if (rst) begin
      cfg_width  = swle_pkg::FRAME_WIDTH_RESET;
      cfg_height = swle_pkg::FRAME_HEIGHT_RESET;
      cfg_radius = swle_pkg::RADIUS_RESET;
      next_row   = 0;
      next_col   = 0;
    end else begin
      if (write_en) apply_reg(write_index, write_data);
      if (pix_if.valid && pix_if.ready) begin
        predict_pixel(pix_if.pixel);
        accepted_cnt++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_q.size() == 0) begin
          flag_error($sformatf("unexpected result at row %0d col %0d",
                               res_if.row, res_if.col));
        end else begin
          want = expected_q.pop_front();
          if (res_if.row !== want.row)
            flag_error($sformatf("row: got %0d, expected %0d", res_if.row, want.row));
          if (res_if.col !== want.col)
            flag_error($sformatf("col: got %0d, expected %0d", res_if.col, want.col));
          if (res_if.value !== want.value)
            flag_error($sformatf("value at (%0d,%0d): got %0d, expected %0d",
                                 want.row, want.col, res_if.value, want.value));
          if (res_if.is_max !== want.is_max)
            flag_error($sformatf("is_max at (%0d,%0d): got %b, expected %b",
                                 want.row, want.col, res_if.is_max, want.is_max));
          if (res_if.is_min !== want.is_min)
            flag_error($sformatf("is_min at (%0d,%0d): got %b, expected %b",
                                 want.row, want.col, res_if.is_min, want.is_min));
          if (res_if.last !== want.last)
            flag_error($sformatf("last at (%0d,%0d): got %b, expected %b",
                                 want.row, want.col, res_if.last, want.last));
        end
      end
    end
  end

  // Pixel driver: holds a transaction until taken, idles in random bursts
  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_taken) begin
      if (send_gap > 0) begin
        pix_if.valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pixel_q.size() > 0) begin
        pix_if.valid <= 1'b1;
        pix_if.pixel <= pixel_q.pop_front();
        if (idle_en && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 19);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (stall_taken != stall_asked) begin
      stall_taken = stall_asked;
      hold_left = LONG_HOLD;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      hold_left = $urandom_range(0, 18);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || write_en || (pix_if.valid && pix_if.ready) ||
        (res_if.valid && res_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_star_window_local_extrema: errors");
      $finish;
    end
  end

  task automatic push_pixel(input logic [PIXEL_BITS-1:0] pix);
    pixel_q.push_back(pix);
    pushed_cnt++;
  endtask

  task automatic push_pixels(input int n, input int mode);
    logic [31:0] rnd;
    for (int i = 0; i < n; i++) begin
      rnd = $urandom;
      case (mode)
        PIX_NARROW:  push_pixel({6'd0, rnd[1:0]});
        PIX_EXTREME: push_pixel(rnd[0] ? 8'hFF : 8'h00);
        default:     push_pixel(rnd[PIXEL_BITS-1:0]);
      endcase
    end
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                           input logic [DAT_BITS-1:0] data);
    @(negedge clk);
    write_en    <= 1'b1;
    write_index <= idx;
    write_data  <= data;
    @(negedge clk);
    write_en    <= 1'b0;
  endtask

  // All three geometry registers in random order, junk above the width and radius fields
  task automatic configure(input int w, input int h, input int r);
    logic [IDX_BITS-1:0] order [3];
    logic [IDX_BITS-1:0] tmp;
    logic [DAT_BITS-1:0] data;
    logic [31:0]         rnd;
    int j;
    order[0] = swle_pkg::REG_FRAME_WIDTH;
    order[1] = swle_pkg::REG_FRAME_HEIGHT;
    order[2] = swle_pkg::REG_RADIUS;
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 3; i++) begin
      rnd  = $urandom;
      data = rnd[DAT_BITS-1:0];
      case (order[i])
        swle_pkg::REG_FRAME_WIDTH:  data[FW_BITS-1:0] = w[FW_BITS-1:0];
        swle_pkg::REG_FRAME_HEIGHT: data = h[FH_BITS-1:0];
        default:                    data[R_BITS-1:0] = r[R_BITS-1:0];
      endcase
      write_reg(order[i], data);
    end
  endtask

  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || expected_q.size() != 0) @(negedge clk);
  endtask

  // Drained, then let pixels that give no result clear the pipeline
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int r, w, h, weff, heff, n, mode, random_items;
    logic [31:0] rnd;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;
    write_en     = 1'b0;
    write_index  = swle_pkg::REG_FRAME_WIDTH;
    write_data   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset geometry: part of the first row, no centre yet
    push_pixels(40, PIX_FULL);
    wait_idle();

    // lone peak, then a lone pit across a write to an unused index
    configure(3, 3, 1);
    for (int i = 0; i < 9; i++) push_pixel(i == 4 ? 8'hFF : 8'h00);
    for (int i = 0; i < 4; i++) push_pixel(8'hFF);
    wait_idle();
    rnd = $urandom;
    write_reg(REG_UNUSED, rnd[DAT_BITS-1:0]);
    push_pixel(8'h00);
    for (int i = 0; i < 4; i++) push_pixel(8'hFF);
    wait_idle();

    // zero width, height and radius: one-pixel frames, both flags set
    configure(0, 0, 0);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    wait_idle();

    // frame too small for the radius: no centres
    configure(2, 2, 1);
    push_pixels(4, PIX_FULL);
    wait_idle();

    // back-pressure: long receiver hold-off, then a sender pause between frames
    configure(7, 9, 0);
    stall_asked++;
    push_pixels(63, PIX_FULL);
    wait_drained();
    push_pixels(63, PIX_NARROW);
    wait_idle();

    // random geometries: whole frames, sometimes a cut-off frame
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(4, MAX_RADIUS) : $urandom_range(0, 3);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * r + 1)
                                      : 2 * r + 1 + $urandom_range(0, 6);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * r + 1)
                                      : 2 * r + 1 + $urandom_range(0, 6);
      if (w == 1 && $urandom_range(0, 1) == 1) w = 0;
      if (h == 1 && $urandom_range(0, 1) == 1) h = 0;
      weff = (w == 0) ? 1 : w;
      heff = (h == 0) ? 1 : h;
      n = $urandom_range(1, 3) * weff * heff;
      if (weff * heff > 1 && $urandom_range(0, 2) == 0)
        n = n + $urandom_range(1, weff * heff - 1);
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      mode = $urandom_range(PIX_FULL, PIX_EXTREME);
      configure(w, h, r);
      push_pixels(n, mode);
      wait_idle();
      random_items += n;
    end

    // closing frame at full rate, no idling on either side
    idle_en = 1'b0;
    configure(8, 8, 2);
    push_pixels(64, PIX_FULL);
    wait_idle();

    if (error_count == 0)
      $display("tb_star_window_local_extrema: clean");
    else
      $display("tb_star_window_local_extrema: errors");
    $finish;
  end

endmodule
